FILE: hdl/amqpd_pkg.sv
package amqpd_pkg;

    // Register indexes of the configuration port.
    localparam logic [7:0] CfgMaxPayload = 8'd0;
    localparam logic [7:0] CfgEndMarker  = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [31:0] MaxPayloadReset = 32'd134217728;
    localparam logic [7:0]  EndMarkerReset  = 8'd206;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_DONE = 2'd1,
        EV_SIZE = 2'd2,
        EV_MARK = 2'd3
    } event_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_CHAN = 3'd1,
        PH_SIZE = 3'd2,
        PH_DATA = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [31:0] byte_index;
        logic [7:0]  data_byte;
        logic [31:0] payload_size;
        logic [15:0] channel_number;
        logic [7:0]  frame_type;
        event_t      event_res;
    } result_t;

    // Configuration values handed to the parser.
    typedef struct packed {
        logic [31:0] max_payload_bytes;
        logic [7:0]  end_marker;
    } cfg_t;

endpackage

FILE: hdl/amqpd_parser.sv
module amqpd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  amqpd_pkg::cfg_t    cfg,
    output logic               res_valid,
    output amqpd_pkg::result_t res
);
    import amqpd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] pos_reg, pos_next;
    logic [32:0] pos_plus;

    assign pos_plus = {1'b0, pos_reg} + 33'd1;

    // State registers of the parser; they move only when a byte is stepped in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            count_reg <= 2'd0;
            type_reg  <= 8'd0;
            chan_reg  <= 16'd0;
            size_reg  <= 32'd0;
            pos_reg   <= 32'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            chan_reg  <= chan_next;
            size_reg  <= size_next;
            pos_reg   <= pos_next;
        end
    end

    // Next state and the result caused by the current byte.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        type_next  = type_reg;
        chan_next  = chan_reg;
        size_next  = size_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res.event_res = EV_DATA;
        res.data_byte = 8'd0;
        res.byte_index = 32'd0;
        case (phase_reg)
            PH_CHAN: begin
                chan_next = {chan_reg[7:0], rx_byte};
                if (count_reg != 2'd0) begin
                    count_next = 2'd0;
                    size_next  = 32'd0;
                    phase_next = PH_SIZE;
                end else begin
                    count_next = 2'd1;
                end
            end
            PH_SIZE: begin
                size_next = {size_reg[23:0], rx_byte};
                if (count_reg != 2'd3) begin
                    count_next = count_reg + 2'd1;
                end else begin
                    count_next = 2'd0;
                    pos_next   = 32'd0;
                    if (size_next > cfg.max_payload_bytes) begin
                        res_valid     = 1'b1;
                        res.event_res = EV_SIZE;
                        phase_next    = PH_TYPE;
                    end else if (size_next == 32'd0) begin
                        phase_next = PH_END;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res_valid      = 1'b1;
                res.event_res  = EV_DATA;
                res.data_byte  = rx_byte;
                res.byte_index = pos_reg;
                pos_next       = pos_plus[31:0];
                if (pos_plus >= {1'b0, size_reg}) begin
                    phase_next = PH_END;
                end
            end
            PH_END: begin
                res_valid     = 1'b1;
                res.event_res = (rx_byte == cfg.end_marker) ? EV_DONE : EV_MARK;
                phase_next    = PH_TYPE;
            end
            default: begin
                type_next  = rx_byte;
                chan_next  = 16'd0;
                size_next  = 32'd0;
                pos_next   = 32'd0;
                count_next = 2'd0;
                phase_next = PH_CHAN;
            end
        endcase
        // Header fields are reported as they stand after this byte.
        res.frame_type     = type_next;
        res.channel_number = chan_next;
        res.payload_size   = size_next;
    end

endmodule

FILE: hdl/amqp_frame_deframer.sv
// AMQP frame deframer: parses a received byte stream into frame events.
// The s_ stream carries one received byte per request in s_tdata. The m_
// stream carries one result per request: m_tuser holds the event code
// (payload byte, frame complete, size too large, bad end marker) and m_tdata
// holds the frame header together with the payload byte and its index.
// Header bytes give no result; every payload byte, each end marker and an
// oversized size field give exactly one.
// The cfg_ channel writes max_payload_bytes (index 0) and end_marker
// (index 1); other indexes are ignored. cfg_ready is always high. Write it
// only while no bytes are in flight.
// A byte accepted lands in the input register; the parser step turns it into
// its result, if any, which is registered in the result register and shows on m_.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the combinational parser step between the input and result registers.
// Reset (aresetn low, synchronous) clears the parser to wait for a type
// byte, empties both registers and restores the register defaults.
// When the receiver stalls, the result holds in m_tdata/m_tuser; the input
// register takes one more byte only if it is empty, and s_tready then stays
// low until the result is taken.
module amqp_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] frame_type, [23:8] channel_number,
                                   // [55:24] payload_size, [63:56] data_byte,
                                   // [95:64] byte_index
    output logic [1:0]  m_tuser,   // [1:0] event_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import amqpd_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic [7:0] in_byte_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    logic    res_valid;
    result_t res;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload_bytes <= MaxPayloadReset;
            cfg_reg.end_marker        <= EndMarkerReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                CfgMaxPayload: cfg_reg.max_payload_bytes <= cfg_data;
                CfgEndMarker:  cfg_reg.end_marker        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The parser steps when the result register is free or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    amqpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_valid_reg && advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {out_reg.byte_index, out_reg.data_byte, out_reg.payload_size,
                       out_reg.channel_number, out_reg.frame_type};

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amqpd_pkg::*;

    // Indexes that no register answers to; writes there must be dropped.
    localparam logic [7:0] CfgUnusedIndex = 8'd2;
    localparam logic [7:0] CfgTopIndex    = 8'hFF;

    localparam int NumPhases    = 8;
    localparam int PhaseBytes   = 250;
    localparam int SettleCycles = 8;
    localparam int CycleLimit   = 200000;

    // Tracks the frame parser and holds the frame events it should produce.
    class frame_event_board;
        logic [31:0] max_payload = MaxPayloadReset;
        logic [7:0]  end_marker  = EndMarkerReset;
        phase_t      phase       = PH_TYPE;
        logic [1:0]  header_count = '0;
        logic [7:0]  held_type    = '0;
        logic [15:0] held_channel = '0;
        logic [31:0] held_size    = '0;
        logic [31:0] position     = '0;
        result_t     pending_events[$];
        int          failures = 0;
        int          reported = 0;

        function void write_register(logic [7:0] index, logic [31:0] value);
            if (index == CfgMaxPayload) begin
                max_payload = value;
            end else if (index == CfgEndMarker) begin
                end_marker = value[7:0];
            end
        endfunction

        function void queue_event(event_t ev, logic [7:0] data, logic [31:0] index);
            result_t r;
            r.event_res      = ev;
            r.frame_type     = held_type;
            r.channel_number = held_channel;
            r.payload_size   = held_size;
            r.data_byte      = data;
            r.byte_index     = index;
            pending_events.push_back(r);
        endfunction

        // Advances the parser by one accepted byte.
        function void take_rx_byte(logic [7:0] b);
            logic [32:0] next_pos;
            case (phase)
                PH_CHAN: begin
                    held_channel = {held_channel[7:0], b};
                    if (header_count >= 2'd1) begin
                        header_count = '0;
                        held_size = '0;
                        phase = PH_SIZE;
                    end else begin
                        header_count = 2'd1;
                    end
                end
                PH_SIZE: begin
                    held_size = {held_size[23:0], b};
                    if (header_count < 2'd3) begin
                        header_count = header_count + 2'd1;
                    end else begin
                        header_count = '0;
                        position = '0;
                        if (held_size > max_payload) begin
                            queue_event(EV_SIZE, 8'd0, 32'd0);
                            phase = PH_TYPE;
                        end else begin
                            phase = (held_size == 32'd0) ? PH_END : PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    next_pos = {1'b0, position} + 33'd1;
                    queue_event(EV_DATA, b, position);
                    position = next_pos[31:0];
                    if (next_pos >= {1'b0, held_size}) begin
                        phase = PH_END;
                    end
                end
                PH_END: begin
                    queue_event((b == end_marker) ? EV_DONE : EV_MARK, 8'd0, 32'd0);
                    phase = PH_TYPE;
                end
                default: begin
                    // Any phase other than the named ones waits for a type byte.
                    held_type = b;
                    held_channel = '0;
                    held_size = '0;
                    position = '0;
                    header_count = '0;
                    phase = PH_CHAN;
                end
            endcase
        endfunction

        // Compares one delivered event with the oldest one still owed.
        function void check_event(result_t got);
            result_t want;
            if (pending_events.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected event: ev=%0d type=%h chan=%h size=%h data=%h idx=%h",
                             got.event_res, got.frame_type, got.channel_number,
                             got.payload_size, got.data_byte, got.byte_index);
                end
                return;
            end
            want = pending_events.pop_front();
            if (got.event_res !== want.event_res || got.frame_type !== want.frame_type ||
                got.channel_number !== want.channel_number ||
                got.payload_size !== want.payload_size ||
                got.data_byte !== want.data_byte || got.byte_index !== want.byte_index) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("event mismatch: expected ev=%0d type=%h chan=%h size=%h data=%h idx=%h",
                             want.event_res, want.frame_type, want.channel_number,
                             want.payload_size, want.data_byte, want.byte_index);
                    $display("                got      ev=%0d type=%h chan=%h size=%h data=%h idx=%h",
                             got.event_res, got.frame_type, got.channel_number,
                             got.payload_size, got.data_byte, got.byte_index);
                end
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    frame_event_board board = new;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;

    amqp_frame_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("amqp_frame_deframer verification failed");
            $finish;
        end
    end

    // The receiver stalls at random while its idling is enabled.
    always @(posedge aclk) begin
        m_tready <= (rx_idle_on && $urandom_range(99) < 27) ? 1'b0 : 1'b1;
    end

    // Every accepted result request is checked against the board.
    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_res      = event_t'(m_tuser);
            got.frame_type     = m_tdata[7:0];
            got.channel_number = m_tdata[23:8];
            got.payload_size   = m_tdata[55:24];
            got.data_byte      = m_tdata[63:56];
            got.byte_index     = m_tdata[95:64];
            board.check_event(got);
        end
    end

    // Offers one byte and waits until the request is taken. Valid stays high
    // afterwards so back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [7:0] value);
        if (tx_idle_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_rx_byte(value);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [15:0] chan,
                               input logic [31:0] size);
        send_byte(ftype);
        send_byte(chan[15:8]);
        send_byte(chan[7:0]);
        send_byte(size[31:24]);
        send_byte(size[23:16]);
        send_byte(size[15:8]);
        send_byte(size[7:0]);
    endtask

    // Stops sending, waits for every owed event and lets header bytes settle.
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (board.pending_events.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [7:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_register(index, value);
    endtask

    // Reconfigures the parser while it is idle; optionally pokes an unused index.
    task automatic set_config(input logic [31:0] max_bytes, input logic [7:0] marker,
                              input bit poke, input logic [7:0] poke_index);
        drain_events();
        if (poke) begin
            cfg_write(poke_index, $urandom);
        end
        cfg_write(CfgMaxPayload, max_bytes);
        cfg_write(CfgEndMarker, {24'd0, marker});
        cfg_valid <= 1'b0;
    endtask

    // Feeds filler bytes until the parser is back at a frame boundary.
    task automatic resync();
        while (board.phase != PH_TYPE) send_byte(8'($urandom_range(255)));
    endtask

    // One frame of random shape: mostly well formed, some broken.
    task automatic send_random_frame();
        int unsigned     pick;
        int unsigned     cap;
        int unsigned     n;
        logic [31:0]     size;
        longint unsigned span;
        logic [7:0]      ftype;
        logic [7:0]      marker;
        logic [15:0]     chan;
        bit              noisy;
        pick  = $urandom_range(99);
        ftype = 8'($urandom_range(255));
        chan  = 16'($urandom_range(16'hFFFF));
        cap   = (board.max_payload < 24) ? board.max_payload : 24;
        if ($urandom_range(19) == 0) begin
            cap = (board.max_payload < 300) ? board.max_payload : 300;
        end
        span  = 64'hFFFF_FFFF - board.max_payload;
        // Broken headers are only safe when any size they form stays short.
        noisy = (board.max_payload <= 255);
        if (pick >= 80 && pick < 88 && span != 0) begin
            // Oversized declaration: the error comes right after the size bytes.
            case ($urandom_range(2))
                0:       size = board.max_payload + 32'd1;
                1:       size = 32'hFFFF_FFFF;
                default: size = 32'(board.max_payload + 64'd1 + ($urandom % span));
            endcase
            send_header(ftype, chan, size);
        end else if (pick >= 88 && noisy) begin
            if (pick < 95) begin
                // Truncated header followed by whatever comes next.
                send_byte(ftype);
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
            resync();
        end else begin
            size   = $urandom_range(cap);
            marker = board.end_marker;
            if (pick >= 70 && pick < 80) begin
                marker = board.end_marker ^ 8'($urandom_range(1, 255));
            end
            send_header(ftype, chan, size);
            repeat (size) send_byte(8'($urandom_range(255)));
            send_byte(marker);
        end
    endtask

    initial begin
        int unsigned start;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at the reset configuration: all-ones header with a
        // one-byte payload, an empty payload closed by a wrong marker, and
        // the largest possible size rejected.
        send_header(8'hFF, 16'hFFFF, 32'd1);
        send_byte(8'hFF);
        send_byte(EndMarkerReset);
        send_header(8'h00, 16'h0000, 32'd0);
        send_byte(~EndMarkerReset);
        send_header(8'h01, 16'h8001, 32'hFFFF_FFFF);

        // Random traffic, one configuration per phase, extremes included.
        for (int p = 0; p < NumPhases; p++) begin
            case (p)
                0: ;
                1: set_config(32'd0, 8'h00, 1'b0, CfgUnusedIndex);
                2: set_config(32'hFFFF_FFFF, 8'hFF, 1'b0, CfgUnusedIndex);
                3: set_config(32'd1024, 8'($urandom_range(255)), 1'b1, CfgUnusedIndex);
                4: set_config($urandom, 8'($urandom_range(255)), 1'b0, CfgUnusedIndex);
                5: set_config($urandom_range(255), 8'($urandom_range(255)), 1'b1,
                              CfgTopIndex);
                default: set_config($urandom_range(255), 8'($urandom_range(255)), 1'b0,
                                    CfgUnusedIndex);
            endcase
            // One phase runs without any idling on either side.
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            start = bytes_sent;
            while (bytes_sent - start < PhaseBytes) send_random_frame();
        end

        drain_events();
        if (board.failures == 0 && board.pending_events.size() == 0) begin
            $display("amqp_frame_deframer verification clean");
        end else begin
            $display("amqp_frame_deframer verification failed");
        end
        $finish;
    end

endmodule

FILE: amqp_frame_deframer.f
hdl/amqpd_pkg.sv
hdl/amqpd_parser.sv
hdl/amqp_frame_deframer.sv
verif/tb.sv
